@@ design/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg: shared definitions for the circular list engine
// Request and response beat layouts, action and error codes, default sizes.
// ----------------------------------------------------------------------------
package cle_pkg;

   // Default store geometry
   localparam int CAPACITY_DEF     = 16;
   localparam int ELEMENT_BITS_DEF = 32;

   // Action codes carried in a request beat
   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_REMOVE  = 2'd1;
   localparam logic [1:0] ACT_ADVANCE = 2'd2;

   // Error codes carried in a response beat
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               list_empty;
      logic [4:0]         node_count;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [1:0]         error_code;
   } rsp_type;

endpackage

@@ design/cle_ram.sv @@
// ----------------------------------------------------------------------------
// cle_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns the
// contents before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/circular_list_engine.sv @@
// ----------------------------------------------------------------------------
// circular_list_engine: circular linked list with a cursor
// Node store of CAPACITY slots holding elements and next-slot links.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one action per beat: add a value after
//   the cursor, remove the node after the cursor, or advance the cursor.
//   rsp_valid/rsp_stall/rsp_data return one beat per request with the empty
//   flag, node count, front (after cursor) and back (cursor) values and an
//   error code. Rejected requests leave the list unchanged.
// Timing:
//   A request beat lands in an input register; once the response register
//   is free, the list is updated and the response register loaded, which
//   raises rsp_valid. One request is taken every cycle while the response
//   is not stalled. The cursor, its two successors and the front and back
//   elements are held in registers, and each store is read at only one
//   prefetched address per cycle (the slot two nodes past the cursor, or
//   the top of the free stack).
// Reset:
//   reset empties the list; the stores need no clearing pass.
// Stall:
//   a stalled response holds; the input register then fills and req_stall
//   rises until the response beat is taken.
// ----------------------------------------------------------------------------
module circular_list_engine #(
   parameter int CAPACITY     = cle_pkg::CAPACITY_DEF,
   parameter int ELEMENT_BITS = cle_pkg::ELEMENT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cle_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   // Handshake and stage registers
   logic             in_valid_ff, in_valid_in;
   cle_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   cle_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             req_accept, out_free, fire;

   // List state
   logic [SLOT_W-1:0]              cursor_ff, cursor_in;
   logic [SLOT_W-1:0]              next1_ff, next1_in;
   logic [SLOT_W-1:0]              next2_ff, next2_in;
   logic signed [ELEMENT_BITS-1:0] back_ff, back_in;
   logic signed [ELEMENT_BITS-1:0] front_ff, front_in;
   logic [CNT_W-1:0]               size_ff, size_in;
   logic [CNT_W-1:0]               free_len_ff, free_len_in;
   logic [CNT_W-1:0]               fresh_ff, fresh_in;

   // Store ports
   logic                    link_we, item_we, free_we;
   logic [SLOT_W-1:0]       link_wa, item_wa, free_wa;
   logic [SLOT_W-1:0]       link_wd, free_wd;
   logic [ELEMENT_BITS-1:0] item_wd;
   logic [SLOT_W-1:0]       link_ra, item_ra, free_ra;
   logic [SLOT_W-1:0]       link_q, free_q;
   logic [ELEMENT_BITS-1:0] item_q;

   // Same-cycle write forwarding
   logic                    link_hit_ff, item_hit_ff, free_hit_ff;
   logic [SLOT_W-1:0]       link_fwd_ff, free_fwd_ff;
   logic [ELEMENT_BITS-1:0] item_fwd_ff;

   // Prefetched values and derived terms
   logic [SLOT_W-1:0]              link_rd, link_eff, free_rd, new_slot;
   logic signed [ELEMENT_BITS-1:0] item_eff;
   logic signed [63:0]             value_wide, front_wide, back_wide;
   logic [ELEMENT_BITS-1:0]        store_val;
   logic [CNT_W-1:0]               free_top_idx;
   logic [1:0]                     err;

   // Move beats through the input and response registers
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   // Resolve store reads: forwarded write data, and the cursor's link lives in next1
   assign link_rd  = link_hit_ff ? link_fwd_ff : link_q;
   assign link_eff = (next2_ff == cursor_ff) ? next1_ff : link_rd;
   assign item_eff = item_hit_ff ? item_fwd_ff : item_q;
   assign free_rd  = free_hit_ff ? free_fwd_ff : free_q;
   assign new_slot = (free_len_ff != '0) ? free_rd : fresh_ff[SLOT_W-1:0];

   // Fit the element to the store width
   assign value_wide = 64'(in_data_ff.value);
   assign store_val  = value_wide[ELEMENT_BITS-1:0];

   // Apply the action to the list
   always_comb begin
      cursor_in   = cursor_ff;
      next1_in    = next1_ff;
      next2_in    = next2_ff;
      back_in     = back_ff;
      front_in    = front_ff;
      size_in     = size_ff;
      free_len_in = free_len_ff;
      fresh_in    = fresh_ff;
      link_we     = 1'b0;
      link_wa     = cursor_ff;
      link_wd     = next1_ff;
      item_we     = 1'b0;
      item_wa     = new_slot;
      item_wd     = store_val;
      free_we     = 1'b0;
      free_wa     = free_len_ff[SLOT_W-1:0];
      free_wd     = next1_ff;
      err         = cle_pkg::ERR_OK;
      if (fire) begin
         unique case (in_data_ff.action)
            cle_pkg::ACT_ADD: begin
               if (size_ff >= CAP_CNT) begin
                  err = cle_pkg::ERR_FULL;
               end else begin
                  item_we  = 1'b1;
                  size_in  = size_ff + ONE_CNT;
                  front_in = store_val;
                  if (free_len_ff != '0) begin
                     free_len_in = free_len_ff - ONE_CNT;
                  end else begin
                     fresh_in = fresh_ff + ONE_CNT;
                  end
                  if (size_ff == '0) begin
                     cursor_in = new_slot;
                     next1_in  = new_slot;
                     next2_in  = new_slot;
                     back_in   = store_val;
                  end else begin
                     link_we  = 1'b1;
                     link_wa  = new_slot;
                     link_wd  = next1_ff;
                     next1_in = new_slot;
                     next2_in = next1_ff;
                  end
               end
            end
            cle_pkg::ACT_REMOVE: begin
               if (size_ff == '0) begin
                  err = cle_pkg::ERR_EMPTY;
               end else begin
                  free_we     = 1'b1;
                  free_len_in = free_len_ff + ONE_CNT;
                  size_in     = size_ff - ONE_CNT;
                  if (size_ff == ONE_CNT) begin
                     cursor_in = '0;
                  end else begin
                     next1_in = next2_ff;
                     next2_in = (next2_ff == cursor_ff) ? next2_ff : link_eff;
                     front_in = item_eff;
                  end
               end
            end
            cle_pkg::ACT_ADVANCE: begin
               if (size_ff == '0) begin
                  err = cle_pkg::ERR_EMPTY;
               end else begin
                  // Write back the departing cursor's link
                  link_we   = 1'b1;
                  cursor_in = next1_ff;
                  next1_in  = next2_ff;
                  next2_in  = link_eff;
                  back_in   = front_ff;
                  front_in  = item_eff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Prefetch the slot two past the cursor and the free stack top
   assign link_ra      = next2_in;
   assign item_ra      = next2_in;
   assign free_top_idx = free_len_in - ONE_CNT;
   assign free_ra      = free_top_idx[SLOT_W-1:0];

   // Build the response beat
   assign front_wide = 64'(front_in);
   assign back_wide  = 64'(back_in);
   always_comb begin
      rsp_data_in.list_empty  = (size_in == '0);
      rsp_data_in.node_count  = 5'(size_in);
      rsp_data_in.front_value = (size_in == '0) ? 32'sd0 : front_wide[31:0];
      rsp_data_in.back_value  = (size_in == '0) ? 32'sd0 : back_wide[31:0];
      rsp_data_in.error_code  = err;
   end

   cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_q)
   );

   cle_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(CAPACITY)) u_item_ram (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (item_wa),
      .wr_data (item_wd),
      .rd_addr (item_ra),
      .rd_data (item_q)
   );

   cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_wa),
      .wr_data (free_wd),
      .rd_addr (free_ra),
      .rd_data (free_q)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         size_ff      <= '0;
         free_len_ff  <= '0;
         fresh_ff     <= '0;
         link_hit_ff  <= 1'b0;
         item_hit_ff  <= 1'b0;
         free_hit_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         size_ff      <= size_in;
         free_len_ff  <= free_len_in;
         fresh_ff     <= fresh_in;
         link_hit_ff  <= link_we && (link_wa == link_ra);
         item_hit_ff  <= item_we && (item_wa == item_ra);
         free_hit_ff  <= free_we && (free_wa == free_ra);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      next1_ff    <= next1_in;
      next2_ff    <= next2_in;
      back_ff     <= back_in;
      front_ff    <= front_in;
      link_fwd_ff <= link_wd;
      item_fwd_ff <= item_wd;
      free_fwd_ff <= free_wd;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every slot taken from fresh space is either in the list or on the free stack
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      (size_ff + free_len_ff) == fresh_ff)
      else $error("slot accounting out of balance");

   // A waiting response beat reflects the current list size
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.node_count == 5'(size_ff)) &&
                       (rsp_data_ff.list_empty == (size_ff == '0)))
      else $error("response count disagrees with list size");

   // A full error is only reported at capacity
   a_full_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.error_code == cle_pkg::ERR_FULL)) |->
         (size_ff == CAP_CNT))
      else $error("full error below capacity");

   // An empty list parks the cursor on slot zero
   a_empty_cursor: assert property (@(posedge clock) disable iff (reset)
      (size_ff == '0) |-> (cursor_ff == '0))
      else $error("cursor not parked on empty list");

endmodule
